FILE: rtl/saes_pkg.sv
// ----------------------------------------------------------------------------
// saes_pkg
// Shared types, register codes and fixed-point constants for the
// self-adaptive ES mutation core.
// ----------------------------------------------------------------------------
package saes_pkg;

  localparam int FRACTION_BITS_DEFAULT = 16;
  localparam int CFG_INDEX_W           = 3;
  localparam int CFG_DATA_W            = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALUE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_VALUE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_STRATEGY = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TAU_LOCAL    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TAU_GLOBAL   = 3'd4;

  // register reset values
  localparam logic signed [31:0] MAX_VALUE_RESET  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_VALUE_RESET  = 32'sh8000_0000;
  localparam logic [15:0]        TAU_LOCAL_RESET  = 16'd46341;
  localparam logic [15:0]        TAU_GLOBAL_RESET = 16'd46341;

  // fixed-point constants, Q1.30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'd1073741824;

  // 2^(j/16), Q1.30
  localparam logic [30:0] POW2_SIXTEENTHS [16] = '{
    31'd1073741824, 31'd1121280436, 31'd1170923762, 31'd1222764986,
    31'd1276901417, 31'd1333434672, 31'd1392470869, 31'd1454120821,
    31'd1518500250, 31'd1585730000, 31'd1655936265, 31'd1729250827,
    31'd1805811301, 31'd1885761398, 31'd1969251188, 31'd2056437387
  };

  typedef struct packed {
    logic signed [31:0] value;
    logic [30:0]        strategy;
    logic signed [15:0] vector_noise;
    logic signed [15:0] element_noise;
  } saes_item_t;

  typedef struct packed {
    logic signed [31:0] new_value;
    logic [30:0]        new_strategy;
    logic               strategy_clamped;
    logic               value_clamped;
  } saes_result_t;

  typedef struct packed {
    logic signed [31:0] max_value;
    logic signed [31:0] min_value;
    logic [30:0]        min_strategy;
    logic [15:0]        tau_local;
    logic [15:0]        tau_global;
  } saes_cfg_t;

  // strategy times exp mantissa, with the biased exponent code
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] element_noise;
    logic [62:0]        scaled;
    logic [5:0]         exp_code;
  } saes_scaled_t;

endpackage

FILE: rtl/saes_cfg_regs.sv
// ----------------------------------------------------------------------------
// saes_cfg_regs
// Configuration register file; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module saes_cfg_regs
  import saes_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output saes_cfg_t              cfg
);

  // 0.01 in the strategy format
  localparam logic [30:0] MIN_STRATEGY_RESET = 31'((64'd1 << FRACTION_BITS) / 100);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_value    <= MAX_VALUE_RESET;
      cfg.min_value    <= MIN_VALUE_RESET;
      cfg.min_strategy <= MIN_STRATEGY_RESET;
      cfg.tau_local    <= TAU_LOCAL_RESET;
      cfg.tau_global   <= TAU_GLOBAL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_VALUE:    cfg.max_value    <= $signed(cfg_data);
        REG_MIN_VALUE:    cfg.min_value    <= $signed(cfg_data);
        REG_MIN_STRATEGY: cfg.min_strategy <= cfg_data[30:0];
        REG_TAU_LOCAL:    cfg.tau_local    <= cfg_data[15:0];
        REG_TAU_GLOBAL:   cfg.tau_global   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/saes_exp_pipe.sv
// ----------------------------------------------------------------------------
// saes_exp_pipe
// Six-stage pipe: exponent, base-2 conversion, exp mantissa, strategy scale.
// ----------------------------------------------------------------------------
module saes_exp_pipe
  import saes_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  saes_cfg_t    cfg,
  input  logic         in_valid,
  output logic         in_ready,
  input  saes_item_t   in_item,
  output logic         out_valid,
  input  logic         out_ready,
  output saes_scaled_t out_data
);

  localparam int STAGES = 6;

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   en;

  // stage payloads
  logic signed [33:0] e0;
  saes_item_t         it0, it1, it2, it3, it4;
  logic [5:0]         kc1, kc2, kc3, kc4;
  logic [3:0]         j1, j2, j3;
  logic [25:0]        r1;
  logic [25:0]        a2;
  logic [30:0]        p3;
  logic [31:0]        m4;

  logic signed [33:0] e_next;
  logic signed [63:0] y_next;
  logic [55:0]        ar_next;
  logic [51:0]        aa_next;
  logic [30:0]        p_next;
  logic [61:0]        tp_next;
  logic [62:0]        t_next;

  // a stage takes new data when it is empty or its successor moves
  always_comb begin
    en[STAGES] = out_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      en[i] = ~vld[i] | en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_comb begin
    e_next  = $signed({1'b0, cfg.tau_global}) * $signed(in_item.vector_noise)
            + $signed({1'b0, cfg.tau_local}) * $signed(in_item.element_noise);
    y_next  = e0 * $signed({1'b0, LOG2E_Q30});
    ar_next = r1 * LN2_Q30;
    aa_next = a2 * a2;
    p_next  = ONE_Q30 + {5'd0, a2} + {10'd0, aa_next[51:31]};
    tp_next = POW2_SIXTEENTHS[j3] * p3;
    t_next  = it4.strategy * m4;
  end

  // exponent, 28 fraction bits
  always_ff @(posedge clk) begin
    if (en[0]) begin
      e0  <= e_next;
      it0 <= in_item;
    end
  end

  // y = e*log2(e); split into biased integer, table index, remainder
  always_ff @(posedge clk) begin
    if (en[1]) begin
      kc1 <= {~y_next[63], y_next[62:58]};
      j1  <= y_next[57:54];
      r1  <= y_next[53:28];
      it1 <= it0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      kc2 <= kc1;
      j2  <= j1;
      a2  <= ar_next[55:30];
      it2 <= it1;
    end
  end

  // second-order polynomial for 2^r
  always_ff @(posedge clk) begin
    if (en[3]) begin
      kc3 <= kc2;
      j3  <= j2;
      p3  <= p_next;
      it3 <= it2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      kc4 <= kc3;
      m4  <= tp_next[61:30];
      it4 <= it3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_data.value         <= it4.value;
      out_data.element_noise <= it4.element_noise;
      out_data.scaled        <= t_next;
      out_data.exp_code      <= kc4;
    end
  end

endmodule

FILE: rtl/saes_step_pipe.sv
// ----------------------------------------------------------------------------
// saes_step_pipe
// Three-stage pipe: strategy shift and clamp, step product, value clamp.
// ----------------------------------------------------------------------------
module saes_step_pipe
  import saes_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  saes_cfg_t    cfg,
  input  logic         in_valid,
  output logic         in_ready,
  input  saes_scaled_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output saes_result_t out_data
);

  localparam int STAGES = 3;
  // exponent code whose shift would go left of the binary point
  localparam logic [5:0] CODE_TOP   = 6'd63;
  // code at which the product is shifted by zero bits
  localparam logic [5:0] SHIFT_BASE = 6'd62;

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   en;

  logic [30:0]        ns0, ns1;
  logic               sc0, sc1;
  logic signed [31:0] val0, val1;
  logic signed [15:0] en0;
  logic signed [35:0] step1;

  logic [5:0]         shamt;
  logic [62:0]        q;
  logic               over;
  logic [30:0]        ns_sat;
  logic [30:0]        ns_next;
  logic               sc_next;
  logic signed [47:0] prod;
  logic signed [36:0] sum;
  logic signed [36:0] sum_hi;
  logic signed [36:0] sum_next;
  logic               vc_next;

  always_comb begin
    en[STAGES] = out_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      en[i] = ~vld[i] | en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // strategy: undo exponent, saturate, floor at min_strategy
  always_comb begin
    shamt = SHIFT_BASE - in_data.exp_code;
    q     = in_data.scaled >> shamt;
    if (in_data.exp_code == CODE_TOP) begin
      over = |in_data.scaled;
    end else begin
      over = |q[62:31];
    end
    ns_sat = over ? '1 : q[30:0];
    if (ns_sat < cfg.min_strategy) begin
      ns_next = cfg.min_strategy;
      sc_next = 1'b1;
    end else begin
      ns_next = ns_sat;
      sc_next = over;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ns0  <= ns_next;
      sc0  <= sc_next;
      val0 <= in_data.value;
      en0  <= in_data.element_noise;
    end
  end

  assign prod = $signed({1'b0, ns0}) * en0;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ns1   <= ns0;
      sc1   <= sc0;
      val1  <= val0;
      step1 <= prod[47:12];
    end
  end

  // upper bound first, then lower bound
  always_comb begin
    sum    = {{5{val1[31]}}, val1} + {step1[35], step1};
    sum_hi = (sum > 37'(cfg.max_value)) ? 37'(cfg.max_value) : sum;
    if (sum_hi < 37'(cfg.min_value)) begin
      sum_next = 37'(cfg.min_value);
    end else begin
      sum_next = sum_hi;
    end
    vc_next = (sum > 37'(cfg.max_value)) || (sum_hi < 37'(cfg.min_value));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      out_data.new_value        <= sum_next[31:0];
      out_data.new_strategy     <= ns1;
      out_data.strategy_clamped <= sc1;
      out_data.value_clamped    <= vc_next;
    end
  end

endmodule

FILE: rtl/self_adaptive_es_mutation_core.sv
// ----------------------------------------------------------------------------
// self_adaptive_es_mutation_core
// Self-adaptive ES mutation of one (value, strategy) pair per transfer.
// ----------------------------------------------------------------------------
// Usage:
//  - item channel (item_valid/item_ready/item): value, strategy and the two
//    Gaussian samples of one element. One transfer gives one result.
//  - result channel (result_valid/result_ready/result): mutated value and
//    strategy with their clamp flags, in input order.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//    always ready; write only while no item is in flight.
//  - Pipeline: an item passes from its transfer to result_valid through six stages of
//    exponent and strategy scaling, then three of strategy clamp, step, value
//    clamp. Throughput: one item per cycle while result_ready is high, set by
//    the nine pipeline registers each taking one transfer a cycle.
//  - Receiver stall: stages hold their data; empty stages still fill, so
//    item_ready drops only once every stage is occupied.
//  - Reset (rst, synchronous): pipeline emptied, registers to defaults
//    (min_strategy = 0.01 in the chosen fraction format).
// ----------------------------------------------------------------------------
module self_adaptive_es_mutation_core
  import saes_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // item channel
  input  logic                   item_valid,
  output logic                   item_ready,
  input  saes_item_t             item,
  // result channel
  output logic                   result_valid,
  input  logic                   result_ready,
  output saes_result_t           result,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  saes_cfg_t    cfg;
  saes_scaled_t scaled;
  logic         scaled_valid;
  logic         scaled_ready;

  saes_cfg_regs #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // exp(tau_global*N + tau_local*Ni) applied to the strategy
  saes_exp_pipe u_exp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .in_item   (item),
    .out_valid (scaled_valid),
    .out_ready (scaled_ready),
    .out_data  (scaled)
  );

  // strategy clamps, value step and value clamps; last stage is the
  // output register
  saes_step_pipe u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (scaled_valid),
    .in_ready  (scaled_ready),
    .in_data   (scaled),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (result)
  );

endmodule

FILE: test/tb_self_adaptive_es_mutation_core.sv
// ----------------------------------------------------------------------------
// tb_self_adaptive_es_mutation_core
// Self-checking bench for the ES mutation core. A short table of hand-picked
// elements comes first, some with their answers typed in. Random elements
// then run over ten register settings. Every result is checked field by field
// against its typed-in answer or else a bit-exact fixed-point prediction, with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_self_adaptive_es_mutation_core;
  import saes_pkg::*;

  localparam int FRAC            = 16;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int TAIL_CYCLES     = 12;   // longer than the pipeline latency
  localparam int MAX_PRINTED     = 40;

  // indexes outside the register map; writes there must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_NONE_LO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE_HI = 3'd7;

  localparam bit [30:0] STRAT_MAX   = 31'h7FFF_FFFF;
  localparam bit [30:0] FLOOR_RESET = 31'((1 << FRAC) / 100);

  // exp() constants, Q1.30, kept independent of the package copies
  localparam longint    LOG2E_FX = 64'sd1549082005;
  localparam bit [63:0] LN2_FX   = 64'd744261118;
  localparam bit [63:0] UNITY_FX = 64'd1073741824;
  localparam bit [63:0] EXP2_FRAC [16] = '{
    64'd1073741824, 64'd1121280436, 64'd1170923762, 64'd1222764986,
    64'd1276901417, 64'd1333434672, 64'd1392470869, 64'd1454120821,
    64'd1518500250, 64'd1585730000, 64'd1655936265, 64'd1729250827,
    64'd1805811301, 64'd1885761398, 64'd1969251188, 64'd2056437387
  };

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_ready;
  saes_item_t             item;
  logic                   result_valid;
  logic                   result_ready;
  saes_result_t           result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  self_adaptive_es_mutation_core #(.FRACTION_BITS(FRAC)) uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // shadow of the register file, updated on each config transfer
  bit signed [31:0] lim_hi      = 32'sh7FFF_FFFF;
  bit signed [31:0] lim_lo      = 32'sh8000_0000;
  bit [30:0]        strat_floor = FLOOR_RESET;
  bit [15:0]        rate_local  = 16'd46341;
  bit [15:0]        rate_global = 16'd46341;

  saes_result_t pending_results [$];

  // driven alongside each element: a typed-in answer for the monitor
  bit           row_known;
  saes_result_t row_want;

  int idle_pct;    // chance that a sender gap burst starts, in percent
  int stall_pct;   // same for receiver stall bursts
  int errors;
  int n_items;
  int n_results;
  int n_writes;
  int n_sflag;
  int n_vflag;

  typedef struct {
    bit [31:0] value;
    bit [30:0] strategy;
    bit [15:0] vnoise;
    bit [15:0] enoise;
    bit        known;
    bit [31:0] w_value;
    bit [30:0] w_strategy;
    bit        w_sflag;
    bit        w_vflag;
  } directed_row_t;

  // Hand-picked elements, run under reset register values. Rows marked known
  // carry an answer readable by eye: zero strategy always ends at the floor,
  // zero noise leaves the strategy as it is, full noise saturates what sits at a limit.
  directed_row_t directed_rows [21] = '{
    // value        strategy       vnoise    enoise  known  new value     new strategy  s  v
    '{32'h0000_0000, 31'h0,        16'h0000, 16'h0000, 1'b1, 32'h0000_0000, FLOOR_RESET,
      1'b1, 1'b0},
    '{32'h0001_0000, 31'h0001_0000, 16'h0000, 16'h0000, 1'b1, 32'h0001_0000, 31'h0001_0000,
      1'b0, 1'b0},
    '{32'h7FFF_FFFF, STRAT_MAX,    16'h0000, 16'h0000, 1'b1, 32'h7FFF_FFFF, STRAT_MAX,
      1'b0, 1'b0},
    '{32'h8000_0000, 31'h0,        16'h0000, 16'h0000, 1'b1, 32'h8000_0000, FLOOR_RESET,
      1'b1, 1'b0},
    '{32'h7FFF_FFFF, 31'h0,        16'h0000, 16'h7FFF, 1'b1, 32'h7FFF_FFFF, FLOOR_RESET,
      1'b1, 1'b1},
    '{32'h8000_0000, 31'h0,        16'h0000, 16'h8000, 1'b1, 32'h8000_0000, FLOOR_RESET,
      1'b1, 1'b1},
    '{32'h0000_0000, STRAT_MAX,    16'h7FFF, 16'h7FFF, 1'b1, 32'h7FFF_FFFF, STRAT_MAX,
      1'b1, 1'b1},
    '{32'h0000_0000, 31'h1,        16'h8000, 16'h8000, 1'b1, 32'hFFFF_EB88, FLOOR_RESET,
      1'b1, 1'b0},
    '{32'h1234_5678, 31'h0,        16'h7FFF, 16'h8000, 1'b1, 32'h1234_4200, FLOOR_RESET,
      1'b1, 1'b0},
    '{32'h0000_0000, 31'h0001_0000, 16'h1000, 16'h0000, 1'b0, 32'h0, 31'h0, 1'b0, 1'b0},
    '{32'h0000_0000, 31'h0001_0000, 16'h0000, 16'h1000, 1'b0, 32'h0, 31'h0, 1'b0, 1'b0},
    '{32'h0000_0000, 31'h0001_0000, 16'hF000, 16'h1000, 1'b0, 32'h0, 31'h0, 1'b0, 1'b0},
    '{32'h7FFF_0000, 31'h0001_0000, 16'h0000, 16'h7FFF, 1'b0, 32'h0, 31'h0, 1'b0, 1'b0},
    '{32'h8001_0000, 31'h0001_0000, 16'h0000, 16'h8000, 1'b0, 32'h0, 31'h0, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, STRAT_MAX,    16'h8000, 16'h8000, 1'b0, 32'h0, 31'h0, 1'b0, 1'b0},
    '{32'h0001_0000, 31'h0000_0290, 16'hF800, 16'hF800, 1'b0, 32'h0, 31'h0, 1'b0, 1'b0},
    '{32'h5555_5555, 31'h2AAA_AAAA, 16'h5555, 16'hAAAA, 1'b0, 32'h0, 31'h0, 1'b0, 1'b0},
    '{32'hAAAA_AAAA, 31'h5555_5555, 16'hAAAA, 16'h5555, 1'b0, 32'h0, 31'h0, 1'b0, 1'b0},
    '{32'h0000_0000, 31'h0040_0000, 16'h0100, 16'h0200, 1'b0, 32'h0, 31'h0, 1'b0, 1'b0},
    '{32'h0000_0000, 31'h0001_0000, 16'h0800, 16'h0800, 1'b0, 32'h0, 31'h0, 1'b0, 1'b0},
    '{32'h4000_0000, 31'h4000_0000, 16'h1800, 16'h1800, 1'b0, 32'h0, 31'h0, 1'b0, 1'b0}
  };

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction: strategy * exp(tau_g*N + tau_l*Ni), then value + strategy*Ni,
  // both clamped. All shifts floor, as the hardware does.
  // --------------------------------------------------------------------------
  function automatic saes_result_t predict_mutation(saes_item_t it);
    saes_result_t res;
    longint       expo;
    longint       prod;
    longint       sum;
    bit [63:0]    u;
    bit [63:0]    frac;
    bit [63:0]    lin;
    bit [63:0]    poly;
    bit [63:0]    mant;
    bit [63:0]    t;
    bit [63:0]    q;
    int           k;
    int           sh;

    // exponent with 28 fraction bits, then times log2(e) for 58
    expo = longint'(rate_global) * longint'($signed(it.vector_noise))
         + longint'(rate_local) * longint'($signed(it.element_noise));
    u = 64'(expo * LOG2E_FX) ^ {1'b1, 63'b0};   // bias so the integer part is unsigned
    k = int'(u[63:58]) - 32;
    // 2^(j/16) from the table, the rest of the fraction by a 2nd-order series
    frac = {38'b0, u[53:28]};
    lin  = (frac * LN2_FX) >> 30;
    poly = UNITY_FX + lin + ((lin * lin) >> 31);
    mant = (EXP2_FRAC[u[57:54]] * poly) >> 30;
    t    = 64'(it.strategy) * mant;
    sh   = 30 - k;
    res.strategy_clamped = 1'b0;
    if (sh < 0) begin
      q = (t != 64'd0) ? 64'h8000_0000 : 64'd0;
    end else if (sh > 63) begin
      q = 64'd0;
    end else begin
      q = t >> sh;
    end
    if (q > 64'(STRAT_MAX)) begin
      q = 64'(STRAT_MAX);
      res.strategy_clamped = 1'b1;
    end
    if (q < 64'(strat_floor)) begin
      q = 64'(strat_floor);
      res.strategy_clamped = 1'b1;
    end

    prod = longint'(q) * longint'($signed(it.element_noise));
    sum  = longint'($signed(it.value)) + (prod >>> 12);
    res.value_clamped = 1'b0;
    if (sum > longint'(lim_hi)) begin
      sum = longint'(lim_hi);
      res.value_clamped = 1'b1;
    end
    if (sum < longint'(lim_lo)) begin
      sum = longint'(lim_lo);
      res.value_clamped = 1'b1;
    end
    res.new_value    = sum[31:0];
    res.new_strategy = q[30:0];
    return res;
  endfunction

  // Random element. Often realistic: noise within about one sigma, moderate
  // strategies, values away from the limits; the rest spans the full fields or lies near the limits.
  function automatic saes_item_t draw_element();
    saes_item_t  it;
    int unsigned pick;

    pick = $urandom_range(9);
    if (pick < 3) begin
      it.value = $urandom;
    end else if (pick < 7) begin
      it.value = 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
    end else if (pick == 7) begin
      it.value = lim_hi - 32'($urandom_range(0, 4096)) + 32'd64;
    end else begin
      it.value = lim_lo + 32'($urandom_range(0, 4096)) - 32'd64;
    end

    pick = $urandom_range(9);
    if (pick < 5) begin
      it.strategy = 31'($urandom_range(1 << 8, 1 << 22));
    end else if (pick < 7) begin
      it.strategy = 31'($urandom);
    end else if (pick == 7) begin
      it.strategy = 31'($urandom_range(0, 1024));
    end else if (pick == 8) begin
      it.strategy = STRAT_MAX - 31'($urandom_range(0, 1 << 16));
    end else begin
      it.strategy = 31'(strat_floor) + 31'($urandom_range(0, 8)) - 31'd4;
    end

    if ($urandom_range(2) != 0) begin
      it.vector_noise = 16'($urandom_range(0, 16'h2000)) - 16'h1000;
    end else begin
      it.vector_noise = 16'($urandom);
    end
    if ($urandom_range(2) != 0) begin
      it.element_noise = 16'($urandom_range(0, 16'h2000)) - 16'h1000;
    end else begin
      it.element_noise = 16'($urandom);
    end
    return it;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    // keep the log readable if something is badly broken
    if (errors <= MAX_PRINTED) begin
      $display("[%0t] result %0d: %s is %h, predicted %h", $realtime, n_results, field,
               got, want);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: all three channels sampled at the rising edge, after the
  // falling-edge drive has settled.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_VALUE:    lim_hi      = cfg_data;
          REG_MIN_VALUE:    lim_lo      = cfg_data;
          REG_MIN_STRATEGY: strat_floor = cfg_data[30:0];
          REG_TAU_LOCAL:    rate_local  = cfg_data[15:0];
          REG_TAU_GLOBAL:   rate_global = cfg_data[15:0];
          default: ;   // unmapped index: ignored by the core as well
        endcase
      end
      if (item_valid && item_ready) begin
        pending_results.push_back(row_known ? row_want : predict_mutation(item));
        n_items++;
      end
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transfer", result.new_value, 32'h0);
        end else begin
          saes_result_t want;
          want = pending_results.pop_front();
          if (result.new_value !== want.new_value)
            report_mismatch("new_value", result.new_value, want.new_value);
          if (result.new_strategy !== want.new_strategy)
            report_mismatch("new_strategy", 32'(result.new_strategy),
                            32'(want.new_strategy));
          if (result.strategy_clamped !== want.strategy_clamped)
            report_mismatch("strategy_clamped", 32'(result.strategy_clamped),
                            32'(want.strategy_clamped));
          if (result.value_clamped !== want.value_clamped)
            report_mismatch("value_clamped", 32'(result.value_clamped),
                            32'(want.value_clamped));
        end
        n_results++;
        if (result.strategy_clamped === 1'b1) n_sflag++;
        if (result.value_clamped === 1'b1) n_vflag++;
      end
    end
  end

  // Receiver: bursts of random length, each ready or stalled at random.
  initial begin : result_sink
    result_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  end

  // Watchdog: too many cycles without any transfer on any channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] no transfer for %0d cycles, %0d results outstanding", $realtime,
             WATCHDOG_LIMIT, pending_results.size());
    $display("Some tests failed");
    $finish;
  end

  // One element transfer, optionally preceded by a gap burst. Valid stays up
  // after the transfer so the next call can follow back to back. The typed-in
  // answer, if any, is driven with the element so the monitor sees the pair.
  task automatic push_item(input saes_item_t it, input bit known,
                           input saes_result_t want);
    int gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 16);
    @(negedge clk);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= it;
    row_known  <= known;
    row_want   <= want;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_writes++;
  endtask

  // Register settings per phase: reset values, each rate alone at its
  // extremes, floor at both ends, narrow and reversed bounds, then random.
  // High data bits above a register's width are junk on purpose.
  task automatic configure_phase(input int ph);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] swap;
    case (ph)
      0: ;   // keep reset values
      1: begin
        write_reg(REG_TAU_LOCAL, 32'hFFFF_FFFF);
        write_reg(REG_TAU_GLOBAL, 32'h0000_0000);
        write_reg(REG_MIN_STRATEGY, 32'h0000_0000);
        write_reg(REG_NONE_LO, 32'hDEAD_BEEF);
      end
      2: begin
        write_reg(REG_TAU_LOCAL, 32'h0000_0000);
        write_reg(REG_TAU_GLOBAL, 32'h0001_FFFF);
        write_reg(REG_MIN_STRATEGY, 32'hFFFF_FFFF);
      end
      3: begin
        write_reg(REG_MAX_VALUE, 32'h0010_0000);
        write_reg(REG_MIN_VALUE, 32'hFFF0_0000);
        write_reg(REG_MIN_STRATEGY, 32'h0000_4000);
        write_reg(REG_TAU_LOCAL, 32'd23170);
        write_reg(REG_TAU_GLOBAL, 32'd8192);
      end
      4: begin
        // reversed bounds: everything should land on min_value
        write_reg(REG_MAX_VALUE, 32'hFFFF_0000);
        write_reg(REG_MIN_VALUE, 32'h0001_0000);
      end
      5: begin
        write_reg(REG_MAX_VALUE, 32'h8000_0000);
        write_reg(REG_MIN_VALUE, 32'h7FFF_FFFF);
        write_reg(REG_NONE_HI, 32'h0000_0001);
      end
      6: begin
        write_reg(REG_MAX_VALUE, 32'h7FFF_FFFF);
        write_reg(REG_MIN_VALUE, 32'h8000_0000);
        write_reg(REG_MIN_STRATEGY, 32'(FLOOR_RESET));
        write_reg(REG_TAU_LOCAL, 32'h5A5A_B505);
        write_reg(REG_TAU_GLOBAL, 32'hA5A5_B505);
      end
      default: begin
        lo = $urandom;
        hi = $urandom;
        // mostly ordered bounds, now and then reversed
        if ($urandom_range(3) != 0 && $signed(lo) > $signed(hi)) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
        write_reg(REG_MAX_VALUE, hi);
        write_reg(REG_MIN_VALUE, lo);
        write_reg(REG_MIN_STRATEGY, {1'($urandom_range(1)), 15'd0, 16'($urandom)});
        write_reg(REG_TAU_LOCAL, $urandom);
        write_reg(REG_TAU_GLOBAL, $urandom);
        write_reg(3'($urandom_range(REG_NONE_LO, REG_NONE_HI)), $urandom);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    saes_item_t   it;
    saes_result_t want_row;
    int           ph;
    int           n;

    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    row_known  = 1'b0;
    row_want   = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    errors     = 0;
    n_items    = 0;
    n_results  = 0;
    n_writes   = 0;
    n_sflag    = 0;
    n_vflag    = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows under reset register values, with light idling
    idle_pct  = 25;
    stall_pct = 25;
    foreach (directed_rows[i]) begin
      it.value                  = directed_rows[i].value;
      it.strategy               = directed_rows[i].strategy;
      it.vector_noise           = directed_rows[i].vnoise;
      it.element_noise          = directed_rows[i].enoise;
      want_row.new_value        = directed_rows[i].w_value;
      want_row.new_strategy     = directed_rows[i].w_strategy;
      want_row.strategy_clamped = directed_rows[i].w_sflag;
      want_row.value_clamped    = directed_rows[i].w_vflag;
      push_item(it, directed_rows[i].known, want_row);
    end
    drain();

    // random phases; registers change only with the pipe empty
    for (ph = 0; ph < PHASES; ph++) begin
      configure_phase(ph);
      if (ph == PHASES - 1 || ph == 2 || ph == 5) begin
        // full-rate stretches, and a clean finish
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 30;
        stall_pct = 35;
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // mid-phase pause until the pipe has emptied
        if (ph == 3 && n == ITEMS_PER_PHASE / 2) drain();
        push_item(draw_element(), 1'b0, '0);
      end
      drain();
    end

    // catch any stray result after the last one expected
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d table rows and %0d random elements over %0d register settings",
             $size(directed_rows), n_items - $size(directed_rows), PHASES);
    $display("%0d register writes, %0d results (%0d strategy clamps, %0d value clamps), %0d errors",
             n_writes, n_results, n_sflag, n_vflag, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
